[hw/rtl/timed_entry_release_table_core_assert.svh]
// assertion macros for the timed entry release table checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TIMED_ENTRY_RELEASE_TABLE_CORE_ASSERT_SVH
`define TIMED_ENTRY_RELEASE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define TERC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TERC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/terc_pkg.sv]
// shared types and constants for the timed entry release table
// no dependencies
package terc_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam logic       REQ_SCHEDULE   = 1'b0;
    localparam logic       REQ_POLL       = 1'b1;

    localparam logic [1:0] STAT_ADDED     = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_RELEASED  = 2'd2;
    localparam logic [1:0] STAT_NONE      = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [31:0] tgt_time;
        logic [31:0] rty_period;
        logic [7:0]  rty_count;
        logic [15:0] entry_tag;
        logic [31:0] poll_time;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] released_target;
        logic [31:0] released_period;
        logic [7:0]  released_retries;
        logic [15:0] released_tag;
        logic [4:0]  entry_count;
        logic        earliest_valid;
        logic [31:0] earliest_time;
        logic [3:0]  earliest_slot;
    } rsp_t;

    typedef struct packed {
        logic [31:0]         target;
        logic [31:0]         period;
        logic [7:0]          retries;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic load_new;
        logic take_next;
    } cell_ctl_t;

    typedef struct packed {
        logic             clear;
        logic             feed;
        logic             poll;
        logic [CNT_W-1:0] count;
    } scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_idx;
        entry_t           rel;
        logic             min_vld;
        logic [31:0]      min_time;
        logic [IDX_W-1:0] min_slot;
    } scan_res_t;

endpackage

[hw/rtl/terc_cell.sv]
// one table cell: holds an entry, loads a new one or takes its neighbour's
// depends on terc_pkg
module terc_cell
    import terc_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    next_entry,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctl.take_next)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[hw/rtl/terc_scan.sv]
// shared due-time and earliest-target stage fed by the head cell of the ring
// depends on terc_pkg
module terc_scan
    import terc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  scan_ctl_t   ctl,
    input  entry_t      head,
    input  logic [IDX_W-1:0] head_idx,
    input  logic [31:0] now,
    output scan_res_t   res
);

    // stage one: product of the head entry
    logic             s1_vld_reg;
    logic             s1_vld_next;
    entry_t           s1_entry_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [31:0]      s1_prod_reg;

    // stage two: first due entry and running minimum
    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] found_idx_reg;
    entry_t           rel_reg;
    logic             min_vld_reg;
    logic             min_vld_next;
    logic [31:0]      min_time_reg;
    logic [IDX_W-1:0] min_slot_reg;

    logic             in_use;
    logic [31:0]      due;
    logic             hit;
    logic             take_min;
    logic [IDX_W-1:0] pos;

    always_comb
    begin
        in_use   = s1_vld_reg && (CNT_W'(s1_idx_reg) < ctl.count);
        due      = s1_entry_reg.target + s1_prod_reg;
        hit      = in_use && ctl.poll && !found_reg && (due <= now);
        take_min = in_use && !hit && (!min_vld_reg || (s1_entry_reg.target < min_time_reg));
        pos      = s1_idx_reg - IDX_W'(found_reg);

        s1_vld_next  = ctl.feed;
        found_next   = found_reg | hit;
        min_vld_next = min_vld_reg | take_min;
        if (ctl.clear)
        begin
            s1_vld_next  = 1'b0;
            found_next   = 1'b0;
            min_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            min_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            found_reg   <= found_next;
            min_vld_reg <= min_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.feed)
        begin
            s1_entry_reg <= head;
            s1_idx_reg   <= head_idx;
            s1_prod_reg  <= 32'(32'(head.retries) * head.period);
        end
        if (hit)
        begin
            found_idx_reg <= s1_idx_reg;
            rel_reg       <= s1_entry_reg;
        end
        if (take_min)
        begin
            min_time_reg <= s1_entry_reg.target;
            min_slot_reg <= pos;
        end
    end

    always_comb
    begin
        res.found     = found_reg;
        res.found_idx = found_idx_reg;
        res.rel       = rel_reg;
        res.min_vld   = min_vld_reg;
        res.min_time  = min_time_reg;
        res.min_slot  = min_slot_reg;
    end

endmodule

[hw/rtl/timed_entry_release_table_core.sv]
// top level of the timed entry release table: ring of cells, scan stage, control
// depends on terc_pkg, terc_cell, terc_scan
//
// channel   ports          handshake
// request   req            taken when start is high and busy is low
// result    rsp            shown for one cycle while done is high
//
// busy stays high after an accept edge while the ring rotates past the one shared multiply
// and compare unit (S_SCAN), while that unit drains (S_LAST) and while the gap closes (S_DROP)
// a schedule item appends at its accept edge, then both kinds scan the ring
// the result shows for one cycle after that with busy low, and while it shows a new item can be taken
// reset clears the entry count and control; cell contents are not cleared
// the receiver cannot stall, so done is never held
module timed_entry_release_table_core
    import terc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DROP = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] step_reg;
    logic [IDX_W-1:0] step_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             poll_reg;
    logic             poll_next;
    logic             full_reg;
    logic             full_next;
    logic [31:0]      now_reg;
    logic             done_reg;
    logic             done_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             accept;
    logic             is_full;
    logic             append;
    entry_t           new_entry;
    entry_t           cells [DEPTH];
    cell_ctl_t        cell_ctl [DEPTH];
    scan_ctl_t        scan_ctl;
    scan_res_t        scan_res;

    assign accept  = start && (state_reg == S_IDLE);
    assign is_full = (count_reg == CNT_W'(DEPTH));
    assign append  = accept && (req.req_type == REQ_SCHEDULE) && !is_full;

    always_comb
    begin
        new_entry.target  = req.tgt_time;
        new_entry.period  = req.rty_period;
        new_entry.retries = req.rty_count;
        new_entry.tag     = TAG_BITS'(req.entry_tag);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t next_entry;

        if (i == DEPTH - 1)
        begin : g_wrap
            assign next_entry = cells[0];
        end
        else
        begin : g_link
            assign next_entry = cells[i+1];
        end

        always_comb
        begin
            cell_ctl[i].load_new  = append && (count_reg == CNT_W'(i));
            cell_ctl[i].take_next = (state_reg == S_SCAN)
                || ((state_reg == S_DROP) && scan_res.found
                    && (IDX_W'(i) >= scan_res.found_idx));
        end

        terc_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .new_entry  (new_entry),
            .next_entry (next_entry),
            .entry      (cells[i])
        );
    end

    always_comb
    begin
        scan_ctl.clear = accept;
        scan_ctl.feed  = (state_reg == S_SCAN);
        scan_ctl.poll  = poll_reg;
        scan_ctl.count = count_reg;
    end

    terc_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .head     (cells[0]),
        .head_idx (step_reg),
        .now      (now_reg),
        .res      (scan_res)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        poll_next  = poll_reg;
        full_next  = full_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    step_next  = '0;
                    poll_next  = req.req_type;
                    full_next  = is_full;
                    if (append)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_SCAN:
            begin
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DROP;
            end
            S_DROP:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                count_next = count_reg - CNT_W'(scan_res.found);

                if (poll_reg == REQ_POLL)
                begin
                    rsp_next.status = scan_res.found ? STAT_RELEASED : STAT_NONE;
                end
                else
                begin
                    rsp_next.status = full_reg ? STAT_FULL : STAT_ADDED;
                end

                if (scan_res.found)
                begin
                    rsp_next.released_target  = scan_res.rel.target;
                    rsp_next.released_period  = scan_res.rel.period;
                    rsp_next.released_retries = scan_res.rel.retries;
                    rsp_next.released_tag     = 16'(scan_res.rel.tag);
                end
                else
                begin
                    rsp_next.released_target  = '0;
                    rsp_next.released_period  = '0;
                    rsp_next.released_retries = '0;
                    rsp_next.released_tag     = '0;
                end

                rsp_next.entry_count    = 5'(count_next);
                rsp_next.earliest_valid = scan_res.min_vld;
                if (scan_res.min_vld)
                begin
                    rsp_next.earliest_time = scan_res.min_time;
                    rsp_next.earliest_slot = 4'(scan_res.min_slot);
                end
                else
                begin
                    rsp_next.earliest_time = '0;
                    rsp_next.earliest_slot = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
            poll_reg  <= REQ_SCHEDULE;
            full_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            poll_reg  <= poll_next;
            full_reg  <= full_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= req.poll_time;
        end
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[hw/rtl/terc_checker.sv]
// port-level checks for the timed entry release table, bound to the top level
// depends on terc_pkg and timed_entry_release_table_core_assert.svh
`include "timed_entry_release_table_core_assert.svh"

module terc_checker
    import terc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    `TERC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item taken but busy not raised")
    `TERC_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
    `TERC_ASSERT_NOW(a_count_range, done, rsp.entry_count <= 5'(DEPTH), "count beyond depth")
    `TERC_ASSERT_NOW(a_earliest_count, done, rsp.earliest_valid == (|rsp.entry_count), "bad earliest")
    `TERC_ASSERT_NOW(a_release_zero, done && (rsp.status != STAT_RELEASED), (|rsp.released_target) == 1'b0, "bad release")

endmodule

bind timed_entry_release_table_core terc_checker u_terc_checker (.*);

[dv/timed_entry_release_table_checker.sv]
// checker for the timed entry release table: keeps its own copy of the table,
// predicts the result of every accepted item and compares it with the block
// depends on terc_pkg
module timed_entry_release_table_checker
    import terc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    entry_t      slots [DEPTH];
    int unsigned held;
    rsp_t        expected_results [$];

    function automatic rsp_t apply_request(req_t r);
        rsp_t        o;
        int unsigned k;
        int unsigned j;
        logic [31:0] due;
        bit          hit;
        o   = '0;
        hit = 1'b0;
        if (r.req_type == REQ_SCHEDULE)
        begin
            if (held >= DEPTH)
            begin
                o.status = STAT_FULL;
            end
            else
            begin
                slots[held].target  = r.tgt_time;
                slots[held].period  = r.rty_period;
                slots[held].retries = r.rty_count;
                slots[held].tag     = r.entry_tag[TAG_BITS-1:0];
                held++;
                o.status = STAT_ADDED;
            end
        end
        else
        begin
            o.status = STAT_NONE;
            for (k = 0; k < held && !hit; k++)
            begin
                // due time wraps at 32 bits
                due = slots[k].target + 32'(slots[k].retries) * slots[k].period;
                if (due <= r.poll_time)
                begin
                    o.status           = STAT_RELEASED;
                    o.released_target  = slots[k].target;
                    o.released_period  = slots[k].period;
                    o.released_retries = slots[k].retries;
                    o.released_tag     = 16'(slots[k].tag);
                    for (j = k; j + 1 < held; j++)
                        slots[j] = slots[j + 1];
                    held--;
                    hit = 1'b1;
                end
            end
        end
        o.entry_count = 5'(held);
        if (held != 0)
        begin
            o.earliest_valid = 1'b1;
            o.earliest_time  = slots[0].target;
            o.earliest_slot  = '0;
            for (k = 1; k < held; k++)
            begin
                if (slots[k].target < o.earliest_time)
                begin
                    o.earliest_time = slots[k].target;
                    o.earliest_slot = 4'(k);
                end
            end
        end
        return o;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected %h, got %h", name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_r;
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no item waiting: %h", rsp);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(rsp.status));
                    check_field("released_target", exp_r.released_target,
                                rsp.released_target);
                    check_field("released_period", exp_r.released_period,
                                rsp.released_period);
                    check_field("released_retries", 32'(exp_r.released_retries),
                                32'(rsp.released_retries));
                    check_field("released_tag", 32'(exp_r.released_tag),
                                32'(rsp.released_tag));
                    check_field("entry_count", 32'(exp_r.entry_count),
                                32'(rsp.entry_count));
                    check_field("earliest_valid", 32'(exp_r.earliest_valid),
                                32'(rsp.earliest_valid));
                    check_field("earliest_time", exp_r.earliest_time, rsp.earliest_time);
                    check_field("earliest_slot", 32'(exp_r.earliest_slot),
                                32'(rsp.earliest_slot));
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_request(req));
            outstanding = expected_results.size();
        end
    end

endmodule

[dv/testbench.sv]
// top of the timed entry release table bench: clock, reset and item stimulus,
// with the checker beside the block giving the verdict's failure count
// depends on terc_pkg, timed_entry_release_table_core, timed_entry_release_table_checker
module testbench;
    import terc_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;

    timed_entry_release_table_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    timed_entry_release_table_checker i_release_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic req_t schedule_item(logic [31:0] t, logic [31:0] p,
                                           logic [7:0] n, logic [15:0] g);
        req_t r;
        r.req_type   = REQ_SCHEDULE;
        r.tgt_time   = t;
        r.rty_period = p;
        r.rty_count  = n;
        r.entry_tag  = g;
        r.poll_time  = $urandom;
        return r;
    endfunction

    function automatic req_t poll_item(logic [31:0] now);
        req_t r;
        r.req_type   = REQ_POLL;
        r.tgt_time   = $urandom;
        r.rty_period = $urandom;
        r.rty_count  = 8'($urandom);
        r.entry_tag  = 16'($urandom);
        r.poll_time  = now;
        return r;
    endfunction

    // times cluster round a drifting epoch so that polls release some entries
    function automatic logic [31:0] pick_time(logic [31:0] epoch, int unsigned spread);
        case ($urandom_range(7))
            0, 1:    return $urandom;
            2:       return 32'hFFFF_FF00 | $urandom_range(255);
            3:       return $urandom_range(255);
            default: return epoch + $urandom_range(spread);
        endcase
    endfunction

    function automatic req_t random_item(int unsigned sched_pct, logic [31:0] epoch);
        logic [31:0] p;
        logic [7:0]  n;
        p = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
        n = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(6));
        if ($urandom_range(99) < sched_pct)
            return schedule_item(pick_time(epoch, 400), p, n, 16'($urandom));
        return poll_item(pick_time(epoch, 600));
    endfunction

    task automatic send(req_t r);
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(int unsigned n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned burst;
        int unsigned sched_pct;
        int unsigned waited;
        logic [31:0] epoch;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;

        // directed part
        send(poll_item(32'hFFFF_FFFF));
        send(schedule_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
        send(schedule_item(32'h0, 32'h0, 8'h0, 16'h0));
        send(poll_item(32'h0));
        // due time wraps round to zero
        send(schedule_item(32'hFFFF_FFF0, 32'h10, 8'h1, 16'h1234));
        send(poll_item(32'h0));
        // fill the table, with equal earliest targets
        for (int i = 0; i < 15; i++)
            send(schedule_item((i % 3 == 0) ? 32'h40 : 32'h1000 + 32'(i), 32'(i), 8'(i),
                               16'(i)));
        send(schedule_item(32'h5, 32'h5, 8'h5, 16'h5));
        send(poll_item(32'h3F));
        send(poll_item(32'hFFFF_FFFF));
        send(poll_item(32'h40));

        // random part
        sent  = 0;
        epoch = $urandom;
        while (sent < 1750)
        begin
            burst     = $urandom_range(1, 30);
            sched_pct = $urandom_range(15, 85);
            for (int i = 0; i < burst; i++)
            begin
                send(random_item(sched_pct, epoch));
                sent++;
                if ($urandom_range(3) == 0)
                    epoch += $urandom_range(300);
            end
            if ($urandom_range(3) != 0)
                pause($urandom_range(1, 40));
        end
        pause(1);

        waited = 0;
        while (outstanding != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (40)
            @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("timed_entry_release_table_core: match");
        else
            $display("timed_entry_release_table_core: mismatch");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timed_entry_release_table_core: mismatch");
        $finish;
    end

endmodule
